// ===== hw/rtl/tfn_pkg.sv =====
// Shared constants, types and command codes of the triangle face normal block.
package tfn_pkg;

  localparam int VERTEX_SLOTS_DEF = 1024;
  localparam int SLOT_W     = 10;
  localparam int COORD_W    = 16;
  localparam int VERTEX_W   = 3 * COORD_W;
  localparam int EDGE_W     = 17;
  localparam int MUL_W      = 18;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CROSS_W    = 34;
  localparam int HALF_W     = 17;
  localparam int SQ_W       = 67;
  localparam int LEN_W      = 68;
  localparam int NRM_W      = 100;
  localparam int Q_W        = 15;
  localparam int OUT_W      = 16;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;
  localparam int CNT_W      = 4;
  localparam int RANGE_W    = 17;

  localparam logic [CNT_W-1:0] ITER_FIRST = CNT_W'(Q_W - 1);
  localparam logic [CNT_W-1:0] CROSS_LAST = CNT_W'(5);
  localparam logic [CNT_W-1:0] PART_LAST  = CNT_W'(2);
  localparam logic [1:0]       COMP_LAST  = 2'd2;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_B, ST_RD_C, ST_EDGE, ST_CROSS, ST_SQUARE, ST_DRAIN,
    ST_SUM, ST_NINIT, ST_NITER, ST_NSTORE, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_LATCH, OP_RD_B, OP_RD_C, OP_EDGE, OP_MUL,
    OP_SUM, OP_NINIT, OP_NITER, OP_NSTORE, OP_LOAD_OUT
  } dp_op_t;

  // Cross product terms first, in the order the counter issues them.
  typedef enum logic [3:0] {
    M_A1B2, M_A2B1, M_A2B0, M_A0B2, M_A0B1, M_A1B0, M_HH, M_HL, M_LL
  } mul_sel_t;

  typedef struct packed {
    dp_op_t     op;
    mul_sel_t   sel;
    logic [1:0] comp;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
  } dp_sts_t;

endpackage

// ===== hw/rtl/tfn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tfn_ram
  import tfn_pkg::*;
#(
  parameter int WIDTH = VERTEX_W,
  parameter int DEPTH = VERTEX_SLOTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/tfn_ctrl.sv =====
// Controller state machine that sequences the normal datapath and the handshakes.
module tfn_ctrl
  import tfn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_tuser,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tuser == CMD_COMPUTE) begin
          state_nxt = ST_RD_B;
        end
      end
      ST_RD_B: state_nxt = ST_RD_C;
      ST_RD_C: state_nxt = ST_EDGE;
      ST_EDGE: begin
        state_nxt = ST_CROSS;
        cnt_nxt   = '0;
      end
      ST_CROSS: begin
        if (cnt_r == CROSS_LAST) begin
          state_nxt = ST_SQUARE;
          cnt_nxt   = '0;
          comp_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQUARE: begin
        if (cnt_r == PART_LAST) begin
          cnt_nxt = '0;
          if (comp_r == COMP_LAST) begin
            state_nxt = ST_DRAIN;
          end else begin
            comp_nxt = comp_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: state_nxt = ST_SUM;
      ST_SUM: begin
        state_nxt = ST_NINIT;
        comp_nxt  = '0;
      end
      ST_NINIT: begin
        if (sts.len_zero) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_NITER;
          cnt_nxt   = ITER_FIRST;
        end
      end
      ST_NITER: begin
        if (cnt_r == '0) begin
          state_nxt = ST_NSTORE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_NSTORE: begin
        if (comp_r == COMP_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_NINIT;
          comp_nxt  = comp_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd.op        = OP_NONE;
    cmd.sel       = M_A1B2;
    cmd.comp      = comp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = (in_tuser == CMD_WRITE) ? OP_WRITE : OP_LATCH;
        end
      end
      ST_RD_B: cmd.op = OP_RD_B;
      ST_RD_C: cmd.op = OP_RD_C;
      ST_EDGE: cmd.op = OP_EDGE;
      ST_CROSS: begin
        cmd.op  = OP_MUL;
        cmd.sel = mul_sel_t'(cnt_r);
      end
      ST_SQUARE: begin
        cmd.op = OP_MUL;
        case (cnt_r)
          4'd0:    cmd.sel = M_HH;
          4'd1:    cmd.sel = M_HL;
          default: cmd.sel = M_LL;
        endcase
      end
      ST_SUM:    cmd.op = OP_SUM;
      ST_NINIT:  cmd.op = OP_NINIT;
      ST_NITER:  cmd.op = OP_NITER;
      ST_NSTORE: cmd.op = OP_NSTORE;
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_LOAD_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/tfn_dp.sv =====
// Datapath: vertex store, edges, shared multiplier, length and bit-serial normalizer.
module tfn_dp
  import tfn_pkg::*;
#(
  parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
  input  logic                   clk,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tlast,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;

  // Input fields.
  logic [SLOT_W-1:0]  in_slot, in_ca, in_cb, in_cc;
  logic [VERTEX_W-1:0] in_vertex;
  assign in_slot   = in_tdata[9:0];
  assign in_vertex = in_tdata[57:10];
  assign in_ca     = in_tdata[67:58];
  assign in_cb     = in_tdata[77:68];
  assign in_cc     = in_tdata[87:78];

  logic [SLOT_W-1:0] cb_r, cc_r;
  logic              last_r;

  // Vertex store access.
  logic [SLOT_W-1:0]   rd_slot;
  logic [RANGE_W-1:0]  rd_ext, wr_ext;
  logic                rd_ok, rd_ok_r, wr_ok;
  logic [VERTEX_W-1:0] rd_data;

  always_comb begin
    case (cmd.op)
      OP_RD_B: rd_slot = cb_r;
      OP_RD_C: rd_slot = cc_r;
      default: rd_slot = in_ca;
    endcase
  end

  assign rd_ext = {{(RANGE_W-SLOT_W){1'b0}}, rd_slot};
  assign wr_ext = {{(RANGE_W-SLOT_W){1'b0}}, in_slot};
  assign rd_ok  = rd_ext < RANGE_W'(VERTEX_SLOTS);
  assign wr_ok  = wr_ext < RANGE_W'(VERTEX_SLOTS);

  tfn_ram #(
    .WIDTH (VERTEX_W),
    .DEPTH (VERTEX_SLOTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.op == OP_WRITE && wr_ok),
    .wr_addr (wr_ext[AW-1:0]),
    .wr_data (in_vertex),
    .rd_addr (rd_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  // A slot past the store reads as the origin.
  logic signed [COORD_W-1:0] vx, vy, vz;
  assign vx = rd_ok_r ? $signed(rd_data[15:0])  : '0;
  assign vy = rd_ok_r ? $signed(rd_data[31:16]) : '0;
  assign vz = rd_ok_r ? $signed(rd_data[47:32]) : '0;

  logic signed [COORD_W-1:0] v1x_r, v1y_r, v1z_r;
  logic signed [EDGE_W-1:0]  a0_r, a1_r, a2_r, b0_r, b1_r, b2_r;

  // Shared multiplier and its accumulation tag.
  logic signed [CROSS_W-1:0] c_r [3];
  logic [CROSS_W-1:0]        m_abs;
  logic [HALF_W-1:0]         m_hi, m_lo;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  p_r;
  logic                      p_vld_r;
  mul_sel_t                  p_sel_r;
  logic [1:0]                p_comp_r;
  logic [SQ_W-1:0]           sq_r [3];
  logic [SQ_W-1:0]           p_sq;

  assign m_abs = c_r[cmd.comp][CROSS_W-1] ? CROSS_W'(-c_r[cmd.comp])
                                          : CROSS_W'(c_r[cmd.comp]);
  assign m_hi  = m_abs[CROSS_W-1:HALF_W];
  assign m_lo  = m_abs[HALF_W-1:0];

  always_comb begin
    case (cmd.sel)
      M_A1B2:  begin mul_a = MUL_W'(a1_r); mul_b = MUL_W'(b2_r); end
      M_A2B1:  begin mul_a = MUL_W'(a2_r); mul_b = MUL_W'(b1_r); end
      M_A2B0:  begin mul_a = MUL_W'(a2_r); mul_b = MUL_W'(b0_r); end
      M_A0B2:  begin mul_a = MUL_W'(a0_r); mul_b = MUL_W'(b2_r); end
      M_A0B1:  begin mul_a = MUL_W'(a0_r); mul_b = MUL_W'(b1_r); end
      M_A1B0:  begin mul_a = MUL_W'(a1_r); mul_b = MUL_W'(b0_r); end
      M_HH:    begin mul_a = {1'b0, m_hi}; mul_b = {1'b0, m_hi}; end
      M_HL:    begin mul_a = {1'b0, m_hi}; mul_b = {1'b0, m_lo}; end
      default: begin mul_a = {1'b0, m_lo}; mul_b = {1'b0, m_lo}; end
    endcase
  end

  assign p_sq = {{(SQ_W-CROSS_W){1'b0}}, p_r[CROSS_W-1:0]};

  // Normalizer: bit-serial search for q with q^2 * len2 <= comp^2 * 2^28.
  logic [LEN_W-1:0] len_r;
  logic [NRM_W-1:0] acc_r, qs_r, ls_r, rhs_r, trial, qs_take;
  logic [Q_W-1:0]   q_r;
  logic             take;
  logic signed [OUT_W-1:0] n_r [3];

  assign trial   = acc_r + qs_r + ls_r;
  assign take    = trial <= rhs_r;
  assign qs_take = take ? qs_r + {ls_r[NRM_W-2:0], 1'b0} : qs_r;

  logic signed [OUT_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                    out_degen_r, out_last_r;

  always_ff @(posedge clk) begin
    p_vld_r  <= (cmd.op == OP_MUL);
    p_sel_r  <= cmd.sel;
    p_comp_r <= cmd.comp;
    p_r      <= mul_a * mul_b;
    rd_ok_r  <= rd_ok;

    case (cmd.op)
      OP_LATCH: begin
        cb_r   <= in_cb;
        cc_r   <= in_cc;
        last_r <= in_tlast;
      end
      OP_RD_B: begin
        v1x_r <= vx;
        v1y_r <= vy;
        v1z_r <= vz;
      end
      OP_RD_C: begin
        a0_r <= EDGE_W'(vx) - EDGE_W'(v1x_r);
        a1_r <= EDGE_W'(vy) - EDGE_W'(v1y_r);
        a2_r <= EDGE_W'(vz) - EDGE_W'(v1z_r);
      end
      OP_EDGE: begin
        b0_r <= EDGE_W'(vx) - EDGE_W'(v1x_r);
        b1_r <= EDGE_W'(vy) - EDGE_W'(v1y_r);
        b2_r <= EDGE_W'(vz) - EDGE_W'(v1z_r);
      end
      OP_SUM: begin
        len_r <= LEN_W'(sq_r[0]) + LEN_W'(sq_r[1]) + LEN_W'(sq_r[2]);
      end
      OP_NINIT: begin
        acc_r <= '0;
        qs_r  <= '0;
        ls_r  <= {{(NRM_W-LEN_W-28){1'b0}}, len_r, 28'd0};
        rhs_r <= {{(NRM_W-SQ_W-28){1'b0}}, sq_r[cmd.comp], 28'd0};
        q_r   <= '0;
      end
      OP_NITER: begin
        if (take) begin
          acc_r <= trial;
        end
        qs_r <= qs_take >> 1;
        ls_r <= ls_r >> 2;
        q_r  <= {q_r[Q_W-2:0], take};
      end
      OP_NSTORE: begin
        n_r[cmd.comp] <= c_r[cmd.comp][CROSS_W-1] ? -$signed({1'b0, q_r})
                                                  : $signed({1'b0, q_r});
      end
      OP_LOAD_OUT: begin
        out_degen_r <= sts.len_zero;
        out_last_r  <= last_r;
        out_x_r     <= sts.len_zero ? '0 : n_r[0];
        out_y_r     <= sts.len_zero ? '0 : n_r[1];
        out_z_r     <= sts.len_zero ? '0 : n_r[2];
      end
      default: ;
    endcase

    // Products are registered in p_r and folded in by their tag in the cycle after issue.
    if (p_vld_r) begin
      case (p_sel_r)
        M_A1B2:  c_r[0] <= p_r[CROSS_W-1:0];
        M_A2B1:  c_r[0] <= c_r[0] - p_r[CROSS_W-1:0];
        M_A2B0:  c_r[1] <= p_r[CROSS_W-1:0];
        M_A0B2:  c_r[1] <= c_r[1] - p_r[CROSS_W-1:0];
        M_A0B1:  c_r[2] <= p_r[CROSS_W-1:0];
        M_A1B0:  c_r[2] <= c_r[2] - p_r[CROSS_W-1:0];
        M_HH:    sq_r[p_comp_r] <= p_sq << (2 * HALF_W);
        M_HL:    sq_r[p_comp_r] <= sq_r[p_comp_r] + (p_sq << (HALF_W + 1));
        default: sq_r[p_comp_r] <= sq_r[p_comp_r] + p_sq;
      endcase
    end
  end

  assign sts.len_zero = (len_r == '0);
  assign out_tdata    = {out_z_r, out_y_r, out_x_r};
  assign out_tuser    = out_degen_r;
  assign out_tlast    = out_last_r;

endmodule

// ===== hw/rtl/triangle_face_normal_top.sv =====
// Top level of the triangle face normal block: controller plus datapath.
//
// Input channel (in_*): each request either writes one vertex into the store
// (in_tuser low) or asks for the unit normal of the triangle whose corners sit
// in three store slots (in_tuser high); in_tlast marks the last triangle of a
// mesh and comes back as out_tlast. A vertex write gives no result.
// Result channel (out_*): one result per triangle with the Q1.14 normal in
// out_tdata and the zero-length flag in out_tuser; a degenerate triangle gives
// a zero normal.
// A triangle's time from acceptance to the result register is set by the 15-step
// bit-serial normalizer run once per component and by the single shared 18x18
// multiplier; a degenerate triangle skips the normalizer. One request is worked
// on at a time, and the next one is accepted in the cycle after the result is
// loaded.
// The result sits in an output register, so the next request is accepted while
// a result waits; a stalled receiver holds a finished result in its register
// and the block waits before loading the next one.
// Reset clears the controller and the output valid; the vertex store is not
// cleared and a slot reads as garbage until written.
module triangle_face_normal_top
  import tfn_pkg::*;
#(
  parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // vertex_slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // normal_x, normal_y, normal_z
  output logic [OUT_DATA_W-1:0] out_tdata,
  // degenerate
  output logic                  out_tuser,
  output logic                  out_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tfn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  tfn_dp #(
    .VERTEX_SLOTS (VERTEX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
